[rtl/cossim_pkg.sv]
// ============================================================================
// cossim_pkg
// Shared widths, step counts and controller/datapath command types for the
// cosine similarity unit.
// ============================================================================
package cossim_pkg;

    // Accumulator and finishing-arithmetic widths
    localparam int ACC_W      = 48;           // dot and norm accumulators
    localparam int HALF_W     = 24;           // norm half used per partial product
    localparam int PP_W       = 2 * HALF_W;   // one partial product
    localparam int PROD_W     = 2 * ACC_W;    // exact norm product
    localparam int ROOT_W     = ACC_W;        // floor square root of the product
    localparam int SQ_REM_W   = ROOT_W + 2;   // square-root / divide remainder
    localparam int OUT_W      = 16;           // similarity output
    localparam int FRAC_W     = 14;           // Q2.14 fraction bits
    localparam int Q_W        = FRAC_W + 1;   // clamped quotient magnitude
    localparam int ONE_Q14    = 16384;        // 1.0 in Q2.14

    // Sequencer step counts
    localparam int MUL_STEPS  = 4;            // partial products of the norm product
    localparam int SQRT_STEPS = ROOT_W;       // one root bit per step
    localparam int CNT_W      = 6;            // holds up to SQRT_STEPS - 1

    // Commands from the controller to the datapath
    typedef struct packed {
        logic       acc_clear;   // clear the three accumulators
        logic       fin_load;    // capture sign, magnitude and zero flag
        logic       mul_en;      // form one partial product
        logic [1:0] mul_idx;     // which norm halves feed the partial product
        logic       mul_add;     // add the held partial product into the product
        logic       sqrt_step;   // one digit of the square root
        logic       div_init;    // set up the divide and the clamp test
        logic       div_step;    // one quotient bit
        logic       out_load;    // load the result register
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic zero;              // either norm accumulator is zero
    } status_t;

endpackage

[rtl/cossim_dp.sv]
// ============================================================================
// cossim_dp
// Datapath: product stage, saturating accumulators, shared finishing unit
// (partial-product multiplier, digit-by-digit square root, restoring divide)
// and the result register.
// ============================================================================
module cossim_dp #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic signed [SAMPLE_WIDTH-1:0]      elem_a,
    input  logic signed [SAMPLE_WIDTH-1:0]      elem_b,
    input  logic                                in_accept,
    input  cossim_pkg::cmd_t                    cmd,
    output cossim_pkg::status_t                 status,
    output logic signed [cossim_pkg::OUT_W-1:0] similarity,
    output logic                                zero_norm
);

    localparam int P_W = 2 * SAMPLE_WIDTH;
    localparam int A_W = cossim_pkg::ACC_W;

    // Product stage
    logic signed [P_W-1:0] sq_a;
    logic signed [P_W-1:0] sq_b;
    logic signed [P_W-1:0] pdot_reg;
    logic        [P_W-1:0] pna_reg;
    logic        [P_W-1:0] pnb_reg;
    logic                  pvld_reg;

    // Accumulators
    logic signed [A_W-1:0] dot_acc_reg;
    logic signed [A_W-1:0] dot_acc_next;
    logic        [A_W-1:0] na_acc_reg;
    logic        [A_W-1:0] na_acc_next;
    logic        [A_W-1:0] nb_acc_reg;
    logic        [A_W-1:0] nb_acc_next;
    logic signed [A_W:0]   dot_sum;
    logic        [A_W:0]   na_sum;
    logic        [A_W:0]   nb_sum;

    // Finishing unit
    logic                                 zero_reg;
    logic                                 neg_reg;
    logic                                 clamp_reg;
    logic [A_W-1:0]                       mag_reg;
    logic [cossim_pkg::PP_W-1:0]          pp_reg;
    logic [1:0]                           pp_idx_reg;
    logic [cossim_pkg::PROD_W-1:0]        prod_reg;
    logic [cossim_pkg::PROD_W-1:0]        pp_shifted;
    logic [cossim_pkg::SQ_REM_W-1:0]      rem_reg;
    logic [cossim_pkg::ROOT_W-1:0]        root_reg;
    logic [cossim_pkg::ROOT_W-1:0]        root_eff;
    logic [cossim_pkg::FRAC_W-1:0]        quo_reg;
    logic [cossim_pkg::HALF_W-1:0]        mul_a;
    logic [cossim_pkg::HALF_W-1:0]        mul_b;
    logic [cossim_pkg::SQ_REM_W+1:0]      sq_tmp;
    logic [cossim_pkg::SQ_REM_W+1:0]      sq_trial;
    logic [cossim_pkg::SQ_REM_W-1:0]      dv_tmp;
    logic [cossim_pkg::SQ_REM_W-1:0]      dv_div;
    logic [cossim_pkg::Q_W-1:0]           q_mag;

    // Result register
    logic signed [cossim_pkg::OUT_W-1:0]  sim_reg;
    logic                                 zero_norm_reg;

    // Form element products
    assign sq_a = elem_a * elem_a;
    assign sq_b = elem_b * elem_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pvld_reg <= 1'b0;
        end
        else
        begin
            pvld_reg <= in_accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            pdot_reg <= elem_a * elem_b;
            pna_reg  <= unsigned'(sq_a);
            pnb_reg  <= unsigned'(sq_b);
        end
    end

    // Saturating accumulate
    always_comb
    begin
        dot_sum = {dot_acc_reg[A_W-1], dot_acc_reg}
                + {{(A_W + 1 - P_W){pdot_reg[P_W-1]}}, pdot_reg};
        na_sum  = {1'b0, na_acc_reg} + {{(A_W + 1 - P_W){1'b0}}, pna_reg};
        nb_sum  = {1'b0, nb_acc_reg} + {{(A_W + 1 - P_W){1'b0}}, pnb_reg};

        if (dot_sum[A_W] != dot_sum[A_W-1])
        begin
            dot_acc_next = dot_sum[A_W] ? {1'b1, {(A_W - 1){1'b0}}}
                                        : {1'b0, {(A_W - 1){1'b1}}};
        end
        else
        begin
            dot_acc_next = dot_sum[A_W-1:0];
        end
        na_acc_next = na_sum[A_W] ? {A_W{1'b1}} : na_sum[A_W-1:0];
        nb_acc_next = nb_sum[A_W] ? {A_W{1'b1}} : nb_sum[A_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_acc_reg <= '0;
            na_acc_reg  <= '0;
            nb_acc_reg  <= '0;
        end
        else if (cmd.acc_clear)
        begin
            dot_acc_reg <= '0;
            na_acc_reg  <= '0;
            nb_acc_reg  <= '0;
        end
        else if (pvld_reg)
        begin
            dot_acc_reg <= dot_acc_next;
            na_acc_reg  <= na_acc_next;
            nb_acc_reg  <= nb_acc_next;
        end
    end

    assign status.zero = (na_acc_reg == '0) || (nb_acc_reg == '0);

    // Select norm halves and place the held partial product
    always_comb
    begin
        mul_a = cmd.mul_idx[0] ? na_acc_reg[A_W-1:cossim_pkg::HALF_W]
                               : na_acc_reg[cossim_pkg::HALF_W-1:0];
        mul_b = cmd.mul_idx[1] ? nb_acc_reg[A_W-1:cossim_pkg::HALF_W]
                               : nb_acc_reg[cossim_pkg::HALF_W-1:0];
        case ({1'b0, pp_idx_reg[0]} + {1'b0, pp_idx_reg[1]})
            2'd0:    pp_shifted = {{cossim_pkg::PP_W{1'b0}}, pp_reg};
            2'd1:    pp_shifted = {{cossim_pkg::HALF_W{1'b0}}, pp_reg,
                                   {cossim_pkg::HALF_W{1'b0}}};
            default: pp_shifted = {pp_reg, {cossim_pkg::PP_W{1'b0}}};
        endcase
    end

    // Square-root digit and divide step
    always_comb
    begin
        sq_tmp   = {rem_reg, prod_reg[cossim_pkg::PROD_W-1:cossim_pkg::PROD_W-2]};
        sq_trial = {2'b00, root_reg, 2'b01};
        root_eff = (root_reg == '0) ? cossim_pkg::ROOT_W'(1) : root_reg;
        dv_tmp   = {rem_reg[cossim_pkg::SQ_REM_W-2:0], 1'b0};
        dv_div   = {2'b00, root_eff};
        q_mag    = clamp_reg ? cossim_pkg::Q_W'(cossim_pkg::ONE_Q14)
                             : {1'b0, quo_reg};
    end

    // Run the finishing sequence
    always_ff @(posedge clk)
    begin
        if (cmd.fin_load)
        begin
            zero_reg <= status.zero;
            neg_reg  <= dot_acc_reg[A_W-1];
            mag_reg  <= dot_acc_reg[A_W-1] ? unsigned'(-dot_acc_reg)
                                           : unsigned'(dot_acc_reg);
            prod_reg <= '0;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (cmd.mul_en || cmd.mul_add)
        begin
            if (cmd.mul_en)
            begin
                pp_reg     <= mul_a * mul_b;
                pp_idx_reg <= cmd.mul_idx;
            end
            if (cmd.mul_add)
            begin
                prod_reg <= prod_reg + pp_shifted;
            end
        end
        else if (cmd.sqrt_step)
        begin
            prod_reg <= prod_reg << 2;
            if (sq_tmp >= sq_trial)
            begin
                rem_reg  <= cossim_pkg::SQ_REM_W'(sq_tmp - sq_trial);
                root_reg <= {root_reg[cossim_pkg::ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= sq_tmp[cossim_pkg::SQ_REM_W-1:0];
                root_reg <= {root_reg[cossim_pkg::ROOT_W-2:0], 1'b0};
            end
        end
        else if (cmd.div_init)
        begin
            clamp_reg <= (mag_reg >= root_eff);
            rem_reg   <= {2'b00, mag_reg};
            quo_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            if (dv_tmp >= dv_div)
            begin
                rem_reg <= dv_tmp - dv_div;
                quo_reg <= {quo_reg[cossim_pkg::FRAC_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= dv_tmp;
                quo_reg <= {quo_reg[cossim_pkg::FRAC_W-2:0], 1'b0};
            end
        end
    end

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            if (zero_reg)
            begin
                sim_reg <= '0;
            end
            else if (neg_reg)
            begin
                sim_reg <= -signed'(cossim_pkg::OUT_W'(q_mag));
            end
            else
            begin
                sim_reg <= signed'(cossim_pkg::OUT_W'(q_mag));
            end
            zero_norm_reg <= zero_reg;
        end
    end

    assign similarity = sim_reg;
    assign zero_norm  = zero_norm_reg;

endmodule

[rtl/cossim_ctrl.sv]
// ============================================================================
// cossim_ctrl
// Controller: takes element pairs, then sequences multiply, square root,
// divide and result load once per vector; a zero norm skips to the load.
// ============================================================================
module cossim_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                last,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  cossim_pkg::status_t status,
    output cossim_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_ACC,
        S_SUM,
        S_CHK,
        S_MUL,
        S_SQRT,
        S_DCHK,
        S_DIV,
        S_DONE
    } state_t;

    state_t                       state_reg;
    logic [cossim_pkg::CNT_W-1:0] cnt_reg;
    logic                         out_valid_reg;
    logic                         accept;

    assign in_ready  = (state_reg == S_ACC);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    // Decode commands from the state
    always_comb
    begin
        cmd = '0;
        case (state_reg)
            S_CHK:
            begin
                cmd.fin_load = 1'b1;
            end
            S_MUL:
            begin
                cmd.mul_en  = (cnt_reg < cossim_pkg::CNT_W'(cossim_pkg::MUL_STEPS));
                cmd.mul_idx = cnt_reg[1:0];
                cmd.mul_add = (cnt_reg != '0);
            end
            S_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
            end
            S_DCHK:
            begin
                cmd.div_init = 1'b1;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            S_DONE:
            begin
                cmd.out_load  = !out_valid_reg || out_ready;
                cmd.acc_clear = !out_valid_reg || out_ready;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // Hold state, step counter and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_ACC;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_ACC:
                begin
                    if (accept && last)
                    begin
                        state_reg <= S_SUM;
                    end
                end
                S_SUM:
                begin
                    state_reg <= S_CHK;
                end
                S_CHK:
                begin
                    cnt_reg   <= '0;
                    state_reg <= status.zero ? S_DONE : S_MUL;
                end
                S_MUL:
                begin
                    if (cnt_reg == cossim_pkg::CNT_W'(cossim_pkg::MUL_STEPS))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_SQRT;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_SQRT:
                begin
                    if (cnt_reg == cossim_pkg::CNT_W'(cossim_pkg::SQRT_STEPS - 1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_DCHK;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_DCHK:
                begin
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (cnt_reg == cossim_pkg::CNT_W'(cossim_pkg::FRAC_W - 1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_DONE:
                begin
                    if (cmd.out_load)
                    begin
                        state_reg <= S_ACC;
                    end
                end
                default:
                begin
                    state_reg <= S_ACC;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // Stop taking items once the final pair of a vector is in
    a_block_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && last) |=> !in_ready)
        else $error("item taken right after a last item");

    // Never overwrite a result that has not been taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten while pending");

    // No input taken while the finishing unit runs
    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.sqrt_step || cmd.div_step || cmd.mul_en) |-> !in_ready)
        else $error("item taken during finishing sequence");

    // Accumulators clear exactly when a result is loaded
    a_clear_with_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.acc_clear == cmd.out_load)
        else $error("accumulator clear out of step with result load");
`endif

endmodule

[rtl/cosine_similarity_unit_core.sv]
// ============================================================================
// cosine_similarity_unit_core
// Streaming cosine similarity of two signed fixed-point vectors, Q2.14 result.
// ============================================================================
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------
//  in      | in_valid / in_ready  | elem_a, elem_b (signed), last
//  out     | out_valid / out_ready| similarity (signed Q2.14), zero_norm
//
//  Element pairs are taken one per cycle while in_ready is high. After the
//  pair marked last the input stalls while the block settles the
//  accumulators, forms the four partial products of the norm product, runs
//  the bit-serial square root and the bit-serial divide, and loads the
//  result. A zero norm skips the arithmetic.
//  The result register lets the next vector stream in while a result waits;
//  the next load waits until the previous result is taken.
//  rst_n (asynchronous) clears the accumulators and all handshake state.
//
module cosine_similarity_unit_core #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]      elem_a,
    input  logic signed [SAMPLE_WIDTH-1:0]      elem_b,
    input  logic                                last,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [cossim_pkg::OUT_W-1:0] similarity,
    output logic                                zero_norm
);

    cossim_pkg::cmd_t    cmd;
    cossim_pkg::status_t status;

    // Sequence the vector
    cossim_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .last      (last),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Accumulate and finish the arithmetic
    cossim_dp #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .elem_a     (elem_a),
        .elem_b     (elem_b),
        .in_accept  (in_valid && in_ready),
        .cmd        (cmd),
        .status     (status),
        .similarity (similarity),
        .zero_norm  (zero_norm)
    );

endmodule
